>>> src/cnia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnia_pkg: shared types and constants of the CAN node ID allocator
// Field widths, request frame codes, register indexes and the structs passed
// between the sequencer and the table scan unit.
// ----------------------------------------------------------------------------
package cnia_pkg;

  localparam int NODE_W  = 11;
  localparam int UUID_W  = 32;
  localparam int EID_W   = 18;
  localparam int DLC_W   = 4;
  localparam int RANGE_W = 22;
  localparam int LEVEL_W = 2;
  localparam int ENTRY_W = UUID_W + NODE_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [DLC_W-1:0] DLC_INIT = 4'd4;
  localparam logic [EID_W-1:0] EID_EMERGENCY = 18'd1;
  localparam logic [EID_W-1:0] EID_HIGH      = 18'd2;
  localparam logic [EID_W-1:0] EID_NORMAL    = 18'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE_ID     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_EMERGENCY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_NORMAL    = 2'd3;

  typedef logic [NODE_W-1:0] node_id_t;
  typedef logic [NODE_W:0]   node_next_t;
  typedef logic [UUID_W-1:0] uuid_t;

  typedef struct packed {
    logic init;
    logic step;
  } scan_ctl_t;

  typedef struct packed {
    logic       found;
    node_id_t   node;
    node_next_t next;
  } scan_res_t;

endpackage

>>> src/can_node_id_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_node_id_allocator: CAN node ID allocator, organizer side
// Watches received frames, answers INIT requests with ASSIGN results.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one received frame per beat (in_valid/in_stall).
// A frame that is not an INIT request for this node is dropped at once and
// the block stays ready. A request walks the participant table in a RAM,
// one entry per cycle through a shared compare unit, and holds in_stall
// high until its result is loaded. It then emits one ASSIGN beat on the
// output channel (out_valid/out_stall), or none if the unique ID is not in
// the table and the table is full or the level range is exhausted. A result
// sits in an output register; a stalled one holds its payload, and the block
// can take the next frame meanwhile, but waits before its own result if the
// previous one is still not taken. Configuration is written through the
// always ready cfg_ port, by the user only while the block is idle (unchecked).
// Reset empties the table (the entry count goes to zero, no clearing pass)
// and clears all configuration registers to zero.
// ----------------------------------------------------------------------------
module can_node_id_allocator #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [cnia_pkg::NODE_W-1:0]         in_rx_sid,
  input  logic                                in_rx_extended,
  input  logic [cnia_pkg::EID_W-1:0]          in_rx_eid,
  input  logic [cnia_pkg::DLC_W-1:0]          in_rx_dlc,
  input  logic [cnia_pkg::UUID_W-1:0]         in_rx_uuid,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [cnia_pkg::NODE_W-1:0]         out_tx_sid,
  output logic [cnia_pkg::LEVEL_W-1:0]        out_tx_eid,
  output logic [cnia_pkg::UUID_W-1:0]         out_assigned_uuid,
  output logic [cnia_pkg::NODE_W-1:0]         out_assigned_node_id,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cnia_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cnia_pkg::RANGE_W-1:0]        cfg_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  logic [1:0] state_r, state_nxt;

  cnia_pkg::node_id_t                own_id_r;
  logic [cnia_pkg::RANGE_W-1:0]      range_em_r, range_hi_r, range_no_r;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          rd_vld_r, rd_vld_nxt;

  cnia_pkg::uuid_t                   key_r;
  logic [cnia_pkg::LEVEL_W-1:0]      eid_r;
  cnia_pkg::node_id_t                lo_r, hi_r;
  logic [cnia_pkg::RANGE_W-1:0]      sel_range;

  logic                              out_valid_r, out_valid_nxt;
  cnia_pkg::node_id_t                out_sid_r;
  logic [cnia_pkg::LEVEL_W-1:0]      out_eid_r;
  cnia_pkg::uuid_t                   out_uuid_r;
  cnia_pkg::node_id_t                out_node_r;

  logic                              in_acc, is_req, load, wr_en;
  cnia_pkg::node_id_t                load_node;
  cnia_pkg::scan_ctl_t               scan_ctl;
  cnia_pkg::scan_res_t               scan_res;
  logic [cnia_pkg::ENTRY_W-1:0]      rd_data;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign is_req = in_rx_extended && (in_rx_sid == own_id_r) &&
                  (in_rx_eid >= cnia_pkg::EID_EMERGENCY) &&
                  (in_rx_eid <= cnia_pkg::EID_NORMAL) &&
                  (in_rx_dlc == cnia_pkg::DLC_INIT);

  always_comb begin
    case (in_rx_eid)
      cnia_pkg::EID_EMERGENCY: sel_range = range_em_r;
      cnia_pkg::EID_HIGH:      sel_range = range_hi_r;
      default:                 sel_range = range_no_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r   <= '0;
      range_em_r <= '0;
      range_hi_r <= '0;
      range_no_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cnia_pkg::CFG_OWN_NODE_ID:     own_id_r   <= cfg_data[cnia_pkg::NODE_W-1:0];
        cnia_pkg::CFG_RANGE_EMERGENCY: range_em_r <= cfg_data;
        cnia_pkg::CFG_RANGE_HIGH:      range_hi_r <= cfg_data;
        cnia_pkg::CFG_RANGE_NORMAL:    range_no_r <= cfg_data;
        default:                       ;
      endcase
    end
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    rd_vld_nxt = 1'b0;
    count_nxt  = count_r;
    scan_ctl   = '0;
    load       = 1'b0;
    load_node  = scan_res.node;
    wr_en      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && is_req) begin
          state_nxt = ST_SCAN;
          idx_nxt   = '0;
        end
      end
      ST_SCAN: begin
        scan_ctl.init = (idx_r == '0) && !rd_vld_r;
        scan_ctl.step = rd_vld_r;
        if (idx_r < count_r) begin
          idx_nxt    = idx_r + CW'(1);
          rd_vld_nxt = 1'b1;
        end else if (!rd_vld_r) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
          if (scan_res.found) begin
            load = 1'b1;
          end else if (count_r != CW'(TABLE_DEPTH) &&
                       scan_res.next <= {1'b0, hi_r}) begin
            load      = 1'b1;
            load_node = scan_res.next[cnia_pkg::NODE_W-1:0];
            wr_en     = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = (out_valid_r && out_stall) || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r <= idx_nxt;
    if (in_acc && is_req) begin
      key_r <= in_rx_uuid;
      eid_r <= in_rx_eid[cnia_pkg::LEVEL_W-1:0];
      lo_r  <= sel_range[cnia_pkg::RANGE_W-1:cnia_pkg::NODE_W];
      hi_r  <= sel_range[cnia_pkg::NODE_W-1:0];
    end
    if (load) begin
      out_sid_r  <= own_id_r;
      out_eid_r  <= eid_r;
      out_uuid_r <= key_r;
      out_node_r <= load_node;
    end
  end

  cnia_ram #(
    .WIDTH (cnia_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[AW-1:0]),
    .wdata ({key_r, scan_res.next[cnia_pkg::NODE_W-1:0]}),
    .raddr (idx_r[AW-1:0]),
    .rdata (rd_data)
  );

  cnia_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (scan_ctl),
    .key_uuid (key_r),
    .lo       (lo_r),
    .hi       (hi_r),
    .ent_uuid (rd_data[cnia_pkg::ENTRY_W-1:cnia_pkg::NODE_W]),
    .ent_node (rd_data[cnia_pkg::NODE_W-1:0]),
    .res      (scan_res)
  );

  assign out_valid            = out_valid_r;
  assign out_tx_sid           = out_sid_r;
  assign out_tx_eid           = out_eid_r;
  assign out_assigned_uuid    = out_uuid_r;
  assign out_assigned_node_id = out_node_r;

endmodule

>>> src/cnia_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnia_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cnia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/cnia_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnia_scan: table scan unit
// Compares one table entry per step against the requested unique ID and
// tracks the largest in-range node ID plus one (at least the low bound) for the requested level.
// ----------------------------------------------------------------------------
module cnia_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  cnia_pkg::scan_ctl_t ctl,
  input  cnia_pkg::uuid_t     key_uuid,
  input  cnia_pkg::node_id_t  lo,
  input  cnia_pkg::node_id_t  hi,
  input  cnia_pkg::uuid_t     ent_uuid,
  input  cnia_pkg::node_id_t  ent_node,
  output cnia_pkg::scan_res_t res
);

  logic                 found_r, found_nxt;
  cnia_pkg::node_id_t   node_r, node_nxt;
  cnia_pkg::node_next_t next_r, next_nxt;
  cnia_pkg::node_next_t ent_plus;
  logic                 in_range;

  assign ent_plus = {1'b0, ent_node} + cnia_pkg::node_next_t'(1);
  assign in_range = (ent_node >= lo) && (ent_node <= hi);

  always_comb begin
    found_nxt = found_r;
    node_nxt  = node_r;
    next_nxt  = next_r;
    if (ctl.init) begin
      found_nxt = 1'b0;
      next_nxt  = {1'b0, lo};
    end else if (ctl.step) begin
      if (!found_r && ent_uuid == key_uuid) begin
        found_nxt = 1'b1;
        node_nxt  = ent_node;
      end
      if (in_range && ent_plus > next_r) begin
        next_nxt = ent_plus;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
    node_r <= node_nxt;
    next_r <= next_nxt;
  end

  assign res.found = found_r;
  assign res.node  = node_r;
  assign res.next  = next_r;

endmodule
